// ===== sv/tpbg_pkg.sv =====
// ----------------------------------------------------------------------------
// tpbg_pkg
// Types, codes and small arithmetic helpers of the pulse burst generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tpbg_pkg;

  localparam int IDX_W  = 3;   // channel index width
  localparam int TIME_W = 16;  // times, counts, config values
  localparam int MASK_W = 8;   // per-channel bit masks
  localparam int REQ_W  = 4;
  localparam int ST_W   = 3;
  localparam int CFG_W  = 2;   // config register index width

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK    = 4'd0;
  localparam logic [REQ_W-1:0] REQ_START   = 4'd1;
  localparam logic [REQ_W-1:0] REQ_ARM     = 4'd2;
  localparam logic [REQ_W-1:0] REQ_SET_ON  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_SET_OFF = 4'd4;
  localparam logic [REQ_W-1:0] REQ_ON_DN   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_ON_UP   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_OFF_DN  = 4'd7;
  localparam logic [REQ_W-1:0] REQ_OFF_UP  = 4'd8;
  localparam logic [REQ_W-1:0] REQ_READ    = 4'd9;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_BAD_CH   = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO_CNT = 3'd2;
  localparam logic [ST_W-1:0] ST_BUSY     = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd4;

  // Config register indexes
  localparam logic [CFG_W-1:0] CFG_ON_MIN  = 2'd0;
  localparam logic [CFG_W-1:0] CFG_ON_MAX  = 2'd1;
  localparam logic [CFG_W-1:0] CFG_OFF_MIN = 2'd2;
  localparam logic [CFG_W-1:0] CFG_OFF_MAX = 2'd3;

  // Reset values
  localparam logic [TIME_W-1:0] RST_LIM_MIN  = 16'd20;
  localparam logic [TIME_W-1:0] RST_LIM_MAX  = 16'd20000;
  localparam logic [TIME_W-1:0] RST_ON_TIME  = 16'd100;
  localparam logic [TIME_W-1:0] RST_OFF_TIME = 16'd900;
  localparam logic [TIME_W-1:0] RST_COUNT    = 16'd1;
  localparam logic [TIME_W-1:0] RST_STEP     = 16'd2220;  // (20000 - 20) / 9

  // floor(2^16 / 9), used for the divide-by-nine of the nudge step
  localparam logic [12:0] RECIP_9 = 13'd7281;
  localparam logic [16:0] NINE    = 17'd9;

  // Limits and nudge steps handed to every lane
  typedef struct packed {
    logic [TIME_W-1:0] on_min;
    logic [TIME_W-1:0] on_max;
    logic [TIME_W-1:0] off_min;
    logic [TIME_W-1:0] off_max;
    logic [TIME_W-1:0] on_step;
    logic [TIME_W-1:0] off_step;
  } lim_t;

  // Per-lane view of the accepted beat
  typedef struct packed {
    logic              tick;
    logic              cmd;    // command addressed to this lane
    logic [REQ_W-1:0]  req;
    logic [TIME_W-1:0] val;
    logic              lvl;    // this lane's trigger level
  } lane_cmd_t;

  // What one lane reports after the beat
  typedef struct packed {
    logic              drive;
    logic              busy;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] off_time;
    logic [TIME_W-1:0] pulses_left;
    logic [ST_W-1:0]   status;
  } lane_out_t;

  // Request fields the merge stage needs
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
  } sel_t;

  // One result beat
  typedef struct packed {
    logic [MASK_W-1:0] valve_drive;
    logic [MASK_W-1:0] busy_mask;
    logic [ST_W-1:0]   status;
    logic [TIME_W-1:0] on_time_read;
    logic [TIME_W-1:0] off_time_read;
    logic [TIME_W-1:0] pulses_left_read;
  } res_t;

  function automatic logic [TIME_W-1:0] clamp16(input logic [TIME_W-1:0] v,
                                                input logic [TIME_W-1:0] lo,
                                                input logic [TIME_W-1:0] hi);
    logic [TIME_W-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] plus_clamp(input logic [TIME_W-1:0] v,
                                                   input logic [TIME_W-1:0] s,
                                                   input logic [TIME_W-1:0] lo,
                                                   input logic [TIME_W-1:0] hi);
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] r;
    sum = {1'b0, v} + {1'b0, s};
    if (sum > {1'b0, hi}) r = hi;
    else if (sum < {1'b0, lo}) r = lo;
    else r = sum[TIME_W-1:0];
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] minus_step(input logic [TIME_W-1:0] v,
                                                   input logic [TIME_W-1:0] s,
                                                   input logic [TIME_W-1:0] lo);
    logic [TIME_W-1:0] r;
    if (v <= lo || s >= (v - lo)) r = lo;
    else r = v - s;
    return r;
  endfunction

  // span / 9 by reciprocal multiply, one correction, at least 1
  function automatic logic [TIME_W-1:0] step_of(input logic [TIME_W-1:0] span);
    logic [28:0] prod;
    logic [16:0] q;
    logic [16:0] rem;
    logic [16:0] q_fix;
    prod  = {13'd0, span} * {16'd0, RECIP_9};
    q     = {4'd0, prod[28:16]};
    rem   = {1'b0, span} - ((q << 3) + q);
    q_fix = (rem >= NINE) ? q + 17'd1 : q;
    return (q_fix == 17'd0) ? 16'd1 : q_fix[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/tpbg_if.sv =====
// ----------------------------------------------------------------------------
// tpbg_if
// Valid/ready channels of the pulse burst generator: request and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpbg_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic [2:0]  valve_index;
  logic [15:0] request_value;
  logic [7:0]  trigger_levels;

  modport source (output valid, req_type, valve_index, request_value, trigger_levels,
                  input ready);
  modport sink   (input valid, req_type, valve_index, request_value, trigger_levels,
                  output ready);
endinterface

interface tpbg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  valve_drive;
  logic [7:0]  busy_mask;
  logic [2:0]  status;
  logic [15:0] on_time_read;
  logic [15:0] off_time_read;
  logic [15:0] pulses_left_read;

  modport source (output valid, valve_drive, busy_mask, status, on_time_read,
                  off_time_read, pulses_left_read, input ready);
  modport sink   (input valid, valve_drive, busy_mask, status, on_time_read,
                  off_time_read, pulses_left_read, output ready);
endinterface

`default_nettype wire

// ===== sv/tpbg_lane.sv =====
// ----------------------------------------------------------------------------
// tpbg_lane
// One valve channel: times, trigger arming and the burst phase counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbg_lane
  import tpbg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire lane_cmd_t lcmd,
  input  wire lim_t      lim,
  output lane_out_t      lout
);

  logic [TIME_W-1:0] on_time_r, on_time_nxt;
  logic [TIME_W-1:0] off_time_r, off_time_nxt;
  logic [TIME_W-1:0] count_r, count_nxt;
  logic [TIME_W-1:0] phase_r, phase_nxt;
  logic [TIME_W-1:0] pulses_r, pulses_nxt;
  logic              armed_r, armed_nxt;
  logic              active_r, active_nxt;
  logic              high_r, high_nxt;
  logic              seen_r, seen_nxt;

  logic [TIME_W-1:0] on_eff, off_eff;
  logic [TIME_W-1:0] b_phase, b_pulses, ph_inc;
  logic              b_active, b_high, fresh;
  logic [ST_W-1:0]   st;

  // Next state for the beat
  always_comb begin
    // Stored times are clamped into the current limits before use
    on_eff   = clamp16(on_time_r, lim.on_min, lim.on_max);
    off_eff  = clamp16(off_time_r, lim.off_min, lim.off_max);

    on_time_nxt  = on_eff;
    off_time_nxt = off_eff;
    count_nxt    = count_r;
    phase_nxt    = phase_r;
    pulses_nxt   = pulses_r;
    armed_nxt    = armed_r;
    active_nxt   = active_r;
    high_nxt     = high_r;
    seen_nxt     = seen_r;
    st           = ST_OK;

    b_active = active_r;
    b_high   = high_r;
    b_phase  = phase_r;
    b_pulses = pulses_r;
    fresh    = 1'b0;
    ph_inc   = phase_r;

    if (lcmd.tick) begin
      // An armed trigger edge starts a burst unless one is running
      if (armed_r && (lcmd.lvl != seen_r)) begin
        seen_nxt = lcmd.lvl;
        if (!active_r) begin
          b_active = 1'b1;
          b_high   = 1'b1;
          b_phase  = '0;
          b_pulses = (count_r == '0) ? RST_COUNT : count_r;
          fresh    = 1'b1;
        end
      end
      active_nxt = b_active;
      high_nxt   = b_high;
      phase_nxt  = b_phase;
      pulses_nxt = b_pulses;
      // Phase counter, saturating; a fresh burst is not advanced
      if (b_active) begin
        ph_inc = (!fresh && b_phase != '1) ? b_phase + 16'd1 : b_phase;
        if (b_high) begin
          if (ph_inc >= on_eff) begin
            high_nxt  = 1'b0;
            phase_nxt = '0;
          end else begin
            phase_nxt = ph_inc;
          end
        end else if (ph_inc >= off_eff) begin
          phase_nxt = '0;
          if (b_pulses > 16'd1) begin
            pulses_nxt = b_pulses - 16'd1;
            high_nxt   = 1'b1;
          end else begin
            pulses_nxt = '0;
            active_nxt = 1'b0;
          end
        end else begin
          phase_nxt = ph_inc;
        end
      end
    end else if (lcmd.cmd) begin
      case (lcmd.req)
        REQ_START: begin
          if (active_r) begin
            st = ST_BUSY;
          end else begin
            active_nxt = 1'b1;
            high_nxt   = 1'b1;
            phase_nxt  = '0;
            pulses_nxt = (lcmd.val == '0) ? RST_COUNT : lcmd.val;
          end
        end
        REQ_ARM: begin
          if (lcmd.val == '0) begin
            st = ST_ZERO_CNT;
          end else begin
            count_nxt = lcmd.val;
            armed_nxt = 1'b1;
            seen_nxt  = lcmd.lvl;
          end
        end
        REQ_SET_ON:  on_time_nxt  = clamp16(lcmd.val, lim.on_min, lim.on_max);
        REQ_SET_OFF: off_time_nxt = clamp16(lcmd.val, lim.off_min, lim.off_max);
        REQ_ON_DN:   on_time_nxt  = minus_step(on_eff, lim.on_step, lim.on_min);
        REQ_ON_UP:   on_time_nxt  = plus_clamp(on_eff, lim.on_step, lim.on_min, lim.on_max);
        REQ_OFF_DN:  off_time_nxt = minus_step(off_eff, lim.off_step, lim.off_min);
        REQ_OFF_UP:  off_time_nxt = plus_clamp(off_eff, lim.off_step, lim.off_min,
                                               lim.off_max);
        default: ;
      endcase
    end
  end

  // State registers, updated on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r  <= RST_ON_TIME;
      off_time_r <= RST_OFF_TIME;
      count_r    <= RST_COUNT;
      phase_r    <= '0;
      pulses_r   <= '0;
      armed_r    <= 1'b0;
      active_r   <= 1'b0;
      high_r     <= 1'b0;
      seen_r     <= 1'b0;
    end else if (accept) begin
      on_time_r  <= on_time_nxt;
      off_time_r <= off_time_nxt;
      count_r    <= count_nxt;
      phase_r    <= phase_nxt;
      pulses_r   <= pulses_nxt;
      armed_r    <= armed_nxt;
      active_r   <= active_nxt;
      high_r     <= high_nxt;
      seen_r     <= seen_nxt;
    end
  end

  // Values after the beat, for the merge stage
  always_comb begin
    lout.drive       = active_nxt && high_nxt;
    lout.busy        = active_nxt;
    lout.on_time     = on_time_nxt;
    lout.off_time    = off_time_nxt;
    lout.pulses_left = pulses_nxt;
    lout.status      = st;
  end

  // A running burst always has a pulse left
  a_active_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pulses_r != '0))
    else $error("tpbg_lane: active burst with no pulses left");

  // High phase only inside a burst
  a_high_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
    high_r |-> active_r)
    else $error("tpbg_lane: high phase outside a burst");

endmodule

`default_nettype wire

// ===== sv/tpbg_merge.sv =====
// ----------------------------------------------------------------------------
// tpbg_merge
// Combines the lane reports into one result and holds it in an output
// register with a skid stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpbg_merge
  import tpbg_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire sel_t      sel,
  input  wire lane_out_t lres [CHANNELS],
  output logic           can_take,
  tpbg_out_if.source     out_ch
);

  res_t res;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic ch_ok, pop;
  logic [ST_W-1:0] lane_st;

  // Merge lane reports
  always_comb begin
    ch_ok   = {1'b0, sel.idx} < (IDX_W+1)'(CHANNELS);
    res     = '0;
    lane_st = ST_OK;
    for (int c = 0; c < CHANNELS; c++) begin
      res.valve_drive[c] = lres[c].drive;
      res.busy_mask[c]   = lres[c].busy;
      if (sel.idx == IDX_W'(c)) begin
        res.on_time_read     = lres[c].on_time;
        res.off_time_read    = lres[c].off_time;
        res.pulses_left_read = lres[c].pulses_left;
        lane_st              = lres[c].status;
      end
    end
    if (sel.req > REQ_READ) res.status = ST_UNKNOWN;
    else if (sel.req != REQ_TICK && !ch_ok) res.status = ST_BAD_CH;
    else if (sel.req != REQ_TICK) res.status = lane_st;
    else res.status = ST_OK;
  end

  // Output register plus skid entry
  always_comb begin
    pop            = out_valid_r && out_ch.ready;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = push;
        if (push) skid_data_nxt = res;
      end else begin
        out_valid_nxt = push;
        if (push) out_data_nxt = res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign can_take                = !skid_valid_r;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.valve_drive      = out_data_r.valve_drive;
  assign out_ch.busy_mask        = out_data_r.busy_mask;
  assign out_ch.status           = out_data_r.status;
  assign out_ch.on_time_read     = out_data_r.on_time_read;
  assign out_ch.off_time_read    = out_data_r.off_time_read;
  assign out_ch.pulses_left_read = out_data_r.pulses_left_read;

  // Skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("tpbg_merge: skid entry without output beat");

endmodule

`default_nettype wire

// ===== sv/triggered_pulse_burst_generator_unit.sv =====
// ----------------------------------------------------------------------------
// triggered_pulse_burst_generator_unit
// Multi-channel valve burst generator: one lane per channel, a shared
// limits/step block and a merge stage with an output skid buffer.
// ----------------------------------------------------------------------------
//  port     dir   kind              beat contents
//  in_ch    in    valid/ready       req_type, valve_index, request_value,
//                                   trigger_levels
//  out_ch   out   valid/ready       valve_drive, busy_mask, status, reads
//  cfg_*    in    write enable      cfg_index selects on/off min/max
//
//  One request beat per cycle while in_ch.ready is high; all lanes update
//  in the accepting cycle. Results leave via the output register (through
//  the skid entry while out_ch stalls). A reg + skid pair holds one extra
//  beat during an output stall; in_ch.ready drops only while the skid
//  entry is full. Reset is synchronous; no clearing pass.
//  A config write updates limits and the nudge step at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module triggered_pulse_burst_generator_unit
  import tpbg_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  tpbg_in_if.sink                in_ch,
  tpbg_out_if.source             out_ch,
  input  wire logic              cfg_wr_en,
  input  wire logic [CFG_W-1:0]  cfg_index,
  input  wire logic [TIME_W-1:0] cfg_wdata
);

  lim_t              lim_r, lim_nxt;
  logic [TIME_W-1:0] span, step;
  logic              cfg_ok, on_side;
  logic              accept, can_take;
  sel_t              sel;
  lane_cmd_t         lcmd [CHANNELS];
  lane_out_t         lres [CHANNELS];

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = can_take;

  // Limit writes: ignored when they would break min < max
  always_comb begin
    lim_nxt = lim_r;
    cfg_ok  = 1'b0;
    on_side = 1'b1;
    span    = '0;
    case (cfg_index)
      CFG_ON_MIN: begin
        cfg_ok = cfg_wdata < lim_r.on_max;
        span   = lim_r.on_max - cfg_wdata;
        lim_nxt.on_min = cfg_wdata;
      end
      CFG_ON_MAX: begin
        cfg_ok = cfg_wdata > lim_r.on_min;
        span   = cfg_wdata - lim_r.on_min;
        lim_nxt.on_max = cfg_wdata;
      end
      CFG_OFF_MIN: begin
        on_side = 1'b0;
        cfg_ok  = cfg_wdata < lim_r.off_max;
        span    = lim_r.off_max - cfg_wdata;
        lim_nxt.off_min = cfg_wdata;
      end
      CFG_OFF_MAX: begin
        on_side = 1'b0;
        cfg_ok  = cfg_wdata > lim_r.off_min;
        span    = cfg_wdata - lim_r.off_min;
        lim_nxt.off_max = cfg_wdata;
      end
      default: ;
    endcase
    // Shared step unit: one write at a time
    step = step_of(span);
    if (on_side) lim_nxt.on_step = step;
    else lim_nxt.off_step = step;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.on_min   <= RST_LIM_MIN;
      lim_r.on_max   <= RST_LIM_MAX;
      lim_r.off_min  <= RST_LIM_MIN;
      lim_r.off_max  <= RST_LIM_MAX;
      lim_r.on_step  <= RST_STEP;
      lim_r.off_step <= RST_STEP;
    end else if (cfg_wr_en && cfg_ok) begin
      lim_r <= lim_nxt;
    end
  end

  // Channel lanes
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    always_comb begin
      lcmd[c].tick = in_ch.req_type == REQ_TICK;
      lcmd[c].cmd  = (in_ch.req_type inside {[REQ_START:REQ_READ]}) &&
                     (in_ch.valve_index == IDX_W'(c));
      lcmd[c].req  = in_ch.req_type;
      lcmd[c].val  = in_ch.request_value;
      lcmd[c].lvl  = in_ch.trigger_levels[c];
    end

    tpbg_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .accept (accept),
      .lcmd   (lcmd[c]),
      .lim    (lim_r),
      .lout   (lres[c])
    );
  end

  // Merge and output
  assign sel.req = in_ch.req_type;
  assign sel.idx = in_ch.valve_index;

  tpbg_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .sel      (sel),
    .lres     (lres),
    .can_take (can_take),
    .out_ch   (out_ch)
  );

  // Limits keep their order
  a_on_order: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r.on_min < lim_r.on_max)
    else $error("tpbg: on limits out of order");

  a_off_order: assert property (@(posedge clk) disable iff (!rst_n)
    lim_r.off_min < lim_r.off_max)
    else $error("tpbg: off limits out of order");

  // A rejected limit write leaves the limits alone
  a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_wr_en && !cfg_ok) |=> $stable(lim_r))
    else $error("tpbg: rejected limit write changed the limits");

endmodule

`default_nettype wire

// ===== tb/triggered_pulse_burst_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// triggered_pulse_burst_generator_unit_tb
// Self-checking bench for the valve burst generator. A short table of
// directed request beats runs first, then phases of random beats, each phase
// under its own on/off time limits. A behavioral model of the channels
// predicts every result beat, and a scoreboard checks each returned beat.
// ----------------------------------------------------------------------------

module triggered_pulse_burst_generator_unit_tb;
  import tpbg_pkg::*;

  localparam int CHANNELS    = 2;
  localparam int NPHASE      = 14;
  localparam int PHASE_BEATS = 125;
  localparam int STALL_LIMIT = 500;

  // request codes the block does not know
  localparam logic [REQ_W-1:0] REQ_BAD_LO = 4'd10;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 4'd15;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [IDX_W-1:0]  idx;
    logic [TIME_W-1:0] val;
    logic [MASK_W-1:0] lvl;
  } beat_t;

  typedef struct {
    beat_t b;
    bit    typed;
    res_t  want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_index;
  logic [TIME_W-1:0] cfg_wdata;

  tpbg_in_if  in_if ();
  tpbg_out_if out_if ();

  triggered_pulse_burst_generator_unit #(.CHANNELS(CHANNELS)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Channel model: limits, per-channel times and burst progress
  // --------------------------------------------------------------------------
  int lim_on_lo, lim_on_hi, lim_off_lo, lim_off_hi;
  bit reclamp;
  logic [TIME_W-1:0] t_on      [CHANNELS];
  logic [TIME_W-1:0] t_off     [CHANNELS];
  logic [TIME_W-1:0] trig_cnt  [CHANNELS];
  logic [TIME_W-1:0] phase_cnt [CHANNELS];
  logic [TIME_W-1:0] left      [CHANNELS];
  logic              armed     [CHANNELS];
  logic              active    [CHANNELS];
  logic              high      [CHANNELS];
  logic              last_lvl  [CHANNELS];

  res_t     valve_results_due [$];
  dir_row_t dir_tab [$];
  int       mismatches;
  bit       jitter_on;
  logic [MASK_W-1:0] trig_now;

  function automatic void model_reset();
    lim_on_lo  = RST_LIM_MIN;
    lim_on_hi  = RST_LIM_MAX;
    lim_off_lo = RST_LIM_MIN;
    lim_off_hi = RST_LIM_MAX;
    reclamp    = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      t_on[c]      = RST_ON_TIME;
      t_off[c]     = RST_OFF_TIME;
      trig_cnt[c]  = RST_COUNT;
      phase_cnt[c] = '0;
      left[c]      = '0;
      armed[c]     = 1'b0;
      active[c]    = 1'b0;
      high[c]      = 1'b0;
      last_lvl[c]  = 1'b0;
    end
  endfunction

  function automatic int fit(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // nudge step: a ninth of the span, never zero
  function automatic int nudge(int lo, int hi);
    int s;
    if (hi <= lo) return 1;
    s = (hi - lo) / 9;
    return (s == 0) ? 1 : s;
  endfunction

  function automatic int step_down(int v, int s, int lo);
    if (v <= lo || s >= v - lo) return lo;
    return v - s;
  endfunction

  function automatic logic [ST_W-1:0] open_burst(int c, logic [TIME_W-1:0] n);
    if (active[c]) return ST_BUSY;
    left[c]      = n;
    active[c]    = 1'b1;
    high[c]      = 1'b1;
    phase_cnt[c] = '0;
    return ST_OK;
  endfunction

  // one tick of a channel's burst; a fresh burst holds its count this tick
  function automatic void run_channel(int c, bit fresh);
    if (!active[c]) return;
    if (!fresh && phase_cnt[c] != 16'hFFFF) phase_cnt[c]++;
    if (high[c]) begin
      if (phase_cnt[c] >= t_on[c]) begin
        high[c]      = 1'b0;
        phase_cnt[c] = '0;
      end
    end else if (phase_cnt[c] >= t_off[c]) begin
      phase_cnt[c] = '0;
      if (left[c] > 1) begin
        left[c]--;
        high[c] = 1'b1;
      end else begin
        left[c]   = '0;
        active[c] = 1'b0;
      end
    end
  endfunction

  function automatic res_t predict_valves(beat_t b);
    res_t r;
    bit fresh [CHANNELS];
    logic [ST_W-1:0] st;
    int ch;
    bit ok_ch;
    st    = ST_OK;
    ch    = b.idx;
    ok_ch = (ch < CHANNELS);
    // stored times follow a limit change before the beat is applied
    if (reclamp) begin
      for (int c = 0; c < CHANNELS; c++) begin
        t_on[c]  = 16'(fit(t_on[c], lim_on_lo, lim_on_hi));
        t_off[c] = 16'(fit(t_off[c], lim_off_lo, lim_off_hi));
      end
      reclamp = 1'b0;
    end
    if (b.req == REQ_TICK) begin
      for (int c = 0; c < CHANNELS; c++) begin
        fresh[c] = 1'b0;
        if (armed[c] && b.lvl[c] != last_lvl[c]) begin
          last_lvl[c] = b.lvl[c];
          if (open_burst(c, (trig_cnt[c] == 0) ? 16'd1 : trig_cnt[c]) == ST_OK)
            fresh[c] = 1'b1;
        end
      end
      for (int c = 0; c < CHANNELS; c++) run_channel(c, fresh[c]);
    end else if (b.req > REQ_READ) begin
      st = ST_UNKNOWN;
    end else if (!ok_ch) begin
      st = ST_BAD_CH;
    end else begin
      case (b.req)
        REQ_START: st = open_burst(ch, (b.val == 0) ? 16'd1 : b.val);
        REQ_ARM: begin
          if (b.val == 0) begin
            st = ST_ZERO_CNT;
          end else begin
            trig_cnt[ch] = b.val;
            armed[ch]    = 1'b1;
            last_lvl[ch] = b.lvl[ch];
          end
        end
        REQ_SET_ON:  t_on[ch]  = 16'(fit(b.val, lim_on_lo, lim_on_hi));
        REQ_SET_OFF: t_off[ch] = 16'(fit(b.val, lim_off_lo, lim_off_hi));
        REQ_ON_DN:   t_on[ch]  = 16'(step_down(t_on[ch], nudge(lim_on_lo, lim_on_hi),
                                               lim_on_lo));
        REQ_ON_UP:   t_on[ch]  = 16'(fit(t_on[ch] + nudge(lim_on_lo, lim_on_hi),
                                         lim_on_lo, lim_on_hi));
        REQ_OFF_DN:  t_off[ch] = 16'(step_down(t_off[ch], nudge(lim_off_lo, lim_off_hi),
                                               lim_off_lo));
        REQ_OFF_UP:  t_off[ch] = 16'(fit(t_off[ch] + nudge(lim_off_lo, lim_off_hi),
                                         lim_off_lo, lim_off_hi));
        default: ;
      endcase
    end
    r = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      r.busy_mask[c]   = active[c];
      r.valve_drive[c] = active[c] && high[c];
    end
    r.status = st;
    if (ok_ch) begin
      r.on_time_read     = t_on[ch];
      r.off_time_read    = t_off[ch];
      r.pulses_left_read = left[ch];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic res_t outcome(logic [7:0] d, logic [7:0] bz, logic [ST_W-1:0] s,
                                   logic [15:0] on, logic [15:0] off, logic [15:0] n);
    res_t r;
    r.valve_drive      = d;
    r.busy_mask        = bz;
    r.status           = s;
    r.on_time_read     = on;
    r.off_time_read    = off;
    r.pulses_left_read = n;
    return r;
  endfunction

  task automatic add_row(logic [REQ_W-1:0] req, logic [IDX_W-1:0] idx,
                         logic [TIME_W-1:0] val, logic [MASK_W-1:0] lvl,
                         bit typed, res_t want);
    dir_row_t row;
    row.b     = '{req, idx, val, lvl};
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endtask

  // one request beat; the model runs at the accepting edge
  task automatic send_beat(beat_t b, bit typed, res_t want);
    res_t exp_r;
    @(negedge clk);
    if (jitter_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.req_type       <= b.req;
    in_if.valve_index    <= b.idx;
    in_if.request_value  <= b.val;
    in_if.trigger_levels <= b.lvl;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    exp_r = predict_valves(b);
    valve_results_due.push_back(typed ? want : exp_r);
  endtask

  // stop sending and let every result drain
  task automatic settle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (valve_results_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] idx, int v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 16'(v);
    // out-of-order writes are dropped
    case (idx)
      CFG_ON_MIN:  if (v < lim_on_hi)  begin lim_on_lo  = v; reclamp = 1'b1; end
      CFG_ON_MAX:  if (v > lim_on_lo)  begin lim_on_hi  = v; reclamp = 1'b1; end
      CFG_OFF_MIN: if (v < lim_off_hi) begin lim_off_lo = v; reclamp = 1'b1; end
      CFG_OFF_MAX: if (v > lim_off_lo) begin lim_off_hi = v; reclamp = 1'b1; end
      default: ;
    endcase
  endtask

  // min, max, min again reaches any lo < hi from any legal range
  task automatic set_range(logic [CFG_W-1:0] i_lo, logic [CFG_W-1:0] i_hi, int lo, int hi);
    write_limit(i_lo, lo);
    write_limit(i_hi, hi);
    write_limit(i_lo, lo);
  endtask

  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(0, 48));
    endcase
  endfunction

  function automatic beat_t rand_beat();
    beat_t b;
    int pick;
    pick  = $urandom_range(0, 99);
    b.idx = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(CHANNELS, 7))
                                        : 3'($urandom_range(0, CHANNELS - 1));
    // trigger levels wander slowly so bursts get room to run
    for (int c = 0; c < MASK_W; c++)
      if ($urandom_range(0, 3) == 0) trig_now[c] = ~trig_now[c];
    b.lvl = trig_now;
    b.val = 16'($urandom);
    if (pick < 50) begin
      b.req = REQ_TICK;
    end else if (pick < 58) begin
      b.req = REQ_START;
      b.val = ($urandom_range(0, 199) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    end else if (pick < 65) begin
      b.req = REQ_ARM;
      b.val = 16'($urandom_range(0, 4));
    end else if (pick < 75) begin
      b.req = ($urandom_range(0, 1) == 0) ? REQ_SET_ON : REQ_SET_OFF;
      b.val = pick_time();
    end else if (pick < 90) begin
      case ($urandom_range(0, 3))
        0:       b.req = REQ_ON_DN;
        1:       b.req = REQ_ON_UP;
        2:       b.req = REQ_OFF_DN;
        default: b.req = REQ_OFF_UP;
      endcase
    end else if (pick < 96) begin
      b.req = REQ_READ;
    end else begin
      b.req = 4'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
    end
    return b;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result-side stalls in short bursts
  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (jitter_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (valve_results_due.size() == 0) begin
        $display("%0t: result beat with none expected, expected none, actual status %0d",
                 $time, out_if.status);
        mismatches++;
      end else begin
        want = valve_results_due.pop_front();
        check_field("valve_drive", want.valve_drive, out_if.valve_drive);
        check_field("busy_mask", want.busy_mask, out_if.busy_mask);
        check_field("status", want.status, out_if.status);
        check_field("on_time_read", want.on_time_read, out_if.on_time_read);
        check_field("off_time_read", want.off_time_read, out_if.off_time_read);
        check_field("pulses_left_read", want.pulses_left_read, out_if.pulses_left_read);
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  int stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("triggered_pulse_burst_generator_unit_tb: done, errors");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int on_lo, on_hi, off_lo, off_hi;
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_index            = '0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.req_type       = REQ_TICK;
    in_if.valve_index    = '0;
    in_if.request_value  = '0;
    in_if.trigger_levels = '0;
    mismatches           = 0;
    stall_cycles         = 0;
    jitter_on            = 1'b1;
    trig_now             = '0;
    model_reset();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table under reset limits (20..20000, nudge step 2220)
    add_row(REQ_READ,    0, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 100, 900, 0));
    add_row(REQ_READ,    1, 16'hFFFF,  8'hFF, 1, outcome(0, 0, ST_OK, 100, 900, 0));
    add_row(REQ_BAD_HI,  7, 16'hFFFF,  8'h00, 1, outcome(0, 0, ST_UNKNOWN, 0, 0, 0));
    add_row(REQ_BAD_LO,  0, 16'd0,     8'h00, 1, outcome(0, 0, ST_UNKNOWN, 100, 900, 0));
    add_row(REQ_READ,    2, 16'd0,     8'h00, 1, outcome(0, 0, ST_BAD_CH, 0, 0, 0));
    add_row(REQ_START,   7, 16'd5,     8'h00, 1, outcome(0, 0, ST_BAD_CH, 0, 0, 0));
    add_row(REQ_ARM,     0, 16'd0,     8'h00, 1, outcome(0, 0, ST_ZERO_CNT, 100, 900, 0));
    add_row(REQ_SET_ON,  0, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 20, 900, 0));
    add_row(REQ_SET_ON,  1, 16'hFFFF,  8'h00, 1, outcome(0, 0, ST_OK, 20000, 900, 0));
    add_row(REQ_SET_OFF, 0, 16'hFFFF,  8'h00, 1, outcome(0, 0, ST_OK, 20, 20000, 0));
    add_row(REQ_SET_OFF, 1, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 20000, 20, 0));
    add_row(REQ_ON_DN,   0, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 20, 20000, 0));
    add_row(REQ_ON_UP,   1, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 20000, 20, 0));
    add_row(REQ_OFF_UP,  0, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 20, 20000, 0));
    add_row(REQ_OFF_DN,  1, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 20000, 20, 0));
    add_row(REQ_ON_UP,   0, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 2240, 20000, 0));
    add_row(REQ_OFF_DN,  0, 16'd0,     8'h00, 1, outcome(0, 0, ST_OK, 2240, 17780, 0));
    add_row(REQ_SET_ON,  0, 16'd1,     8'h00, 1, outcome(0, 0, ST_OK, 20, 17780, 0));
    add_row(REQ_SET_OFF, 0, 16'd3,     8'h00, 1, outcome(0, 0, ST_OK, 20, 20, 0));
    // zero count still gives one pulse; a second start is refused
    add_row(REQ_START,   0, 16'd0,     8'h00, 1, outcome(1, 1, ST_OK, 20, 20, 1));
    add_row(REQ_START,   0, 16'd9,     8'h00, 1, outcome(1, 1, ST_BUSY, 20, 20, 1));
    // trigger starts a burst, then toggles while busy are refused
    add_row(REQ_ARM,     1, 16'd3,     8'h00, 0, '0);
    add_row(REQ_TICK,    7, 16'd0,     8'h02, 0, '0);
    add_row(REQ_TICK,    1, 16'd0,     8'h00, 0, '0);
    add_row(REQ_TICK,    0, 16'd0,     8'hFF, 0, '0);

    foreach (dir_tab[i]) send_beat(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);

    // random phases, each under its own limits
    for (int p = 0; p < NPHASE; p++) begin
      settle();
      case (p)
        0: begin on_lo = 0;     on_hi = 65535; off_lo = 0;     off_hi = 65535; end
        1: begin on_lo = 65534; on_hi = 65535; off_lo = 0;     off_hi = 1;     end
        2: begin on_lo = 0;     on_hi = 1;     off_lo = 65534; off_hi = 65535; end
        3: begin on_lo = 0;     on_hi = 2;     off_lo = 0;     off_hi = 2;     end
        default: begin
          on_lo  = $urandom_range(0, 8);
          on_hi  = on_lo + $urandom_range(1, 40);
          off_lo = $urandom_range(0, 8);
          off_hi = off_lo + $urandom_range(1, 40);
        end
      endcase
      write_limit(2'($urandom_range(0, 3)), $urandom_range(0, 65535));
      set_range(CFG_ON_MIN, CFG_ON_MAX, on_lo, on_hi);
      set_range(CFG_OFF_MIN, CFG_OFF_MAX, off_lo, off_hi);
      // writes that break the range order are dropped
      write_limit(CFG_ON_MAX, lim_on_lo);
      write_limit(CFG_OFF_MIN, lim_off_hi);
      @(negedge clk);
      cfg_wr_en <= 1'b0;

      jitter_on = (p % 4 != 3) && (p != NPHASE - 1);
      for (int k = 0; k < PHASE_BEATS; k++) send_beat(rand_beat(), 1'b0, '0);
    end

    settle();
    if (mismatches == 0)
      $display("triggered_pulse_burst_generator_unit_tb: done, clean");
    else
      $display("triggered_pulse_burst_generator_unit_tb: done, errors");
    $finish;
  end

endmodule
